### rtl/cubic_spline_interpolator_macros.svh
// ============================================================================
// Cubic spline interpolator assertion macros
// Concurrent assertion forms for the interpolator top-level design file.
// ============================================================================
`ifndef CUBIC_SPLINE_INTERPOLATOR_MACROS_SVH
`define CUBIC_SPLINE_INTERPOLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cubic spline interpolator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cubic spline interpolator assertion failed");

`endif

### rtl/csi_pkg.sv
// ============================================================================
// Cubic spline interpolator package
// Fixed constants shared by the interpolator interfaces and modules.
// ============================================================================
package csi_pkg;

  localparam int OUT_W    = 51;
  localparam int OUT_FRAC = 16;

  localparam int TURN_BITS     = 16;
  localparam int STEP_HI_LIMIT = 32'sh8001;
  localparam int STEP_LO_LIMIT = -32'sh8000;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic signed [OUT_W-1:0] out_word_t;

endpackage

### rtl/csi_if.sv
// ============================================================================
// Cubic spline interpolator channel interfaces
// Valid/ready channels for the control point input and the result output.
// ============================================================================
interface csi_in_if #(
  parameter int POINT_WIDTH      = 32,
  parameter int WEIGHT_FRAC_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [WEIGHT_FRAC_BITS:0]     weight;
  logic signed [POINT_WIDTH-1:0] point_before;
  logic signed [POINT_WIDTH-1:0] point_start;
  logic signed [POINT_WIDTH-1:0] point_end;
  logic signed [POINT_WIDTH-1:0] point_after;
  logic                          wrap_angles;
  logic                          linear_mode;

  modport source (
    output valid, weight, point_before, point_start, point_end, point_after,
    output wrap_angles, linear_mode,
    input  ready
  );

  modport sink (
    input  valid, weight, point_before, point_start, point_end, point_after,
    input  wrap_angles, linear_mode,
    output ready
  );
endinterface

interface csi_out_if ();
  logic              valid;
  logic              ready;
  csi_pkg::out_word_t value;
  csi_pkg::out_word_t slope;

  modport source (
    output valid, value, slope,
    input  ready
  );

  modport sink (
    input  valid, value, slope,
    output ready
  );
endinterface

### rtl/csi_unwrap.sv
// ============================================================================
// Cubic spline interpolator unwrap stage
// Clamps the weight and unwraps the control points as 16-bit angles.
// ============================================================================
module csi_unwrap #(
  parameter int PW = 32,
  parameter int F  = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [F:0]           weight_i,
  input  logic signed [PW-1:0] point_before_i,
  input  logic signed [PW-1:0] point_start_i,
  input  logic signed [PW-1:0] point_end_i,
  input  logic signed [PW-1:0] point_after_i,
  input  logic                 wrap_angles_i,
  input  logic                 linear_mode_i,
  output logic [F:0]           weight_o,
  output logic signed [PW+2:0] p_o,
  output logic signed [PW+2:0] c_o,
  output logic signed [PW+2:0] n_o,
  output logic signed [PW+2:0] f_o,
  output logic                 lin_o
);

  localparam int UW = PW + 3;
  localparam logic [F:0]         ONE     = {1'b1, {F{1'b0}}};
  localparam logic signed [PW:0] STEP_HI = (PW+1)'(csi_pkg::STEP_HI_LIMIT);
  localparam logic signed [PW:0] STEP_LO = (PW+1)'(csi_pkg::STEP_LO_LIMIT);

  function automatic logic signed [1:0] turn_step(input logic signed [PW:0] d);
    logic signed [1:0] r;
    priority if (d >= STEP_HI) begin
      r = -2'sd1;
    end else if (d < STEP_LO) begin
      r = 2'sd1;
    end else begin
      r = 2'sd0;
    end
    return r;
  endfunction

  logic signed [PW:0] d1, d2, d3;
  logic signed [1:0]  s1, s2, s3;
  logic signed [2:0]  k1, k2, k3;

  logic [F:0]           weight_d, weight_q;
  logic signed [UW-1:0] p_d, c_d, n_d, f_d;
  logic signed [UW-1:0] p_q, c_q, n_q, f_q;
  logic                 lin_d, lin_q;

  // The offsets of earlier points cancel in each later difference.
  assign d1 = (PW+1)'(point_start_i) - (PW+1)'(point_before_i);
  assign d2 = (PW+1)'(point_end_i) - (PW+1)'(point_start_i);
  assign d3 = (PW+1)'(point_after_i) - (PW+1)'(point_end_i);

  assign s1 = wrap_angles_i ? turn_step(d1) : 2'sd0;
  assign s2 = wrap_angles_i ? turn_step(d2) : 2'sd0;
  assign s3 = wrap_angles_i ? turn_step(d3) : 2'sd0;

  assign k1 = 3'(s1);
  assign k2 = k1 + 3'(s2);
  assign k3 = k2 + 3'(s3);

  assign weight_d = (weight_i > ONE) ? ONE : weight_i;
  assign p_d      = UW'(point_before_i);
  assign c_d      = UW'(point_start_i) + (UW'(k1) <<< csi_pkg::TURN_BITS);
  assign n_d      = UW'(point_end_i) + (UW'(k2) <<< csi_pkg::TURN_BITS);
  assign f_d      = UW'(point_after_i) + (UW'(k3) <<< csi_pkg::TURN_BITS);
  assign lin_d    = linear_mode_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      weight_q <= weight_d;
      p_q      <= p_d;
      c_q      <= c_d;
      n_q      <= n_d;
      f_q      <= f_d;
      lin_q    <= lin_d;
    end
  end

  assign weight_o = weight_q;
  assign p_o      = p_q;
  assign c_o      = c_q;
  assign n_o      = n_q;
  assign f_o      = f_q;
  assign lin_o    = lin_q;

endmodule

### rtl/csi_coeff.sv
// ============================================================================
// Cubic spline interpolator coefficient stage
// Forms twice the polynomial coefficients for the value and the slope.
// ============================================================================
module csi_coeff #(
  parameter int PW = 32,
  parameter int F  = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [F:0]           weight_i,
  input  logic signed [PW+2:0] p_i,
  input  logic signed [PW+2:0] c_i,
  input  logic signed [PW+2:0] n_i,
  input  logic signed [PW+2:0] f_i,
  input  logic                 lin_i,
  output logic [F:0]           weight_o,
  output logic signed [PW+8:0] ca_o,
  output logic signed [PW+8:0] sca_o,
  output logic signed [PW+8:0] cb_o,
  output logic signed [PW+8:0] cc_o,
  output logic signed [PW+8:0] cd_o,
  output logic                 lin_o
);

  localparam int CW = PW + 9;

  logic signed [CW-1:0] p_e, c_e, n_e, f_e;
  logic signed [CW-1:0] ca_c, cb_c;

  logic [F:0]           weight_d, weight_q;
  logic signed [CW-1:0] ca_d, sca_d, cb_d, cc_d, cd_d;
  logic signed [CW-1:0] ca_q, sca_q, cb_q, cc_q, cd_q;
  logic                 lin_d, lin_q;

  assign p_e = CW'(p_i);
  assign c_e = CW'(c_i);
  assign n_e = CW'(n_i);
  assign f_e = CW'(f_i);

  assign ca_c = f_e - p_e + (c_e <<< 1) + c_e - ((n_e <<< 1) + n_e);
  assign cb_c = (p_e <<< 1) - ((c_e <<< 2) + c_e) + (n_e <<< 2) - f_e;

  assign weight_d = weight_i;
  assign ca_d     = lin_i ? '0 : ca_c;
  assign sca_d    = lin_i ? '0 : (ca_c <<< 1) + ca_c;
  assign cb_d     = lin_i ? '0 : cb_c;
  assign cc_d     = lin_i ? ((n_e - c_e) <<< 1) : (n_e - p_e);
  assign cd_d     = c_e <<< 1;
  assign lin_d    = lin_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      weight_q <= weight_d;
      ca_q     <= ca_d;
      sca_q    <= sca_d;
      cb_q     <= cb_d;
      cc_q     <= cc_d;
      cd_q     <= cd_d;
      lin_q    <= lin_d;
    end
  end

  assign weight_o = weight_q;
  assign ca_o     = ca_q;
  assign sca_o    = sca_q;
  assign cb_o     = cb_q;
  assign cc_o     = cc_q;
  assign cd_o     = cd_q;
  assign lin_o    = lin_q;

endmodule

### rtl/csi_poly.sv
// ============================================================================
// Cubic spline interpolator polynomial pipeline
// Evaluates the value and slope numerators by Horner steps over six stages.
// ============================================================================
module csi_poly #(
  parameter int PW = 32,
  parameter int F  = 16
) (
  input  logic                 clk_i,
  input  logic [5:0]           en_i,
  input  logic [F:0]           weight_i,
  input  logic signed [PW+8:0] ca_i,
  input  logic signed [PW+8:0] sca_i,
  input  logic signed [PW+8:0] cb_i,
  input  logic signed [PW+8:0] cc_i,
  input  logic signed [PW+8:0] cd_i,
  input  logic                 lin_i,
  output logic signed [PW+3*F+17:0] value_num_o,
  output logic signed [PW+2*F+14:0] slope_num_o,
  output logic                      lin_o
);

  localparam int CW   = PW + 9;
  localparam int W    = F + 1;
  localparam int W1   = W + 1;
  localparam int M1W  = CW + W1;
  localparam int A1W  = M1W + 1;
  localparam int M2W  = A1W + W1;
  localparam int A2W  = M2W + 1;
  localparam int LO_W = A2W / 2;
  localparam int HI_W = A2W - LO_W;
  localparam int LPW  = LO_W + W;
  localparam int HPW  = HI_W + W1;
  localparam int A3W  = A2W + W1 + 1;

  // Stage one: leading coefficient times weight.
  logic signed [M1W-1:0] vm1_d, vm1_q, sm1_d, sm1_q;
  logic signed [CW-1:0]  cb1_q, cc1_q, cd1_q;
  logic [W-1:0]          w1_q;
  logic                  lin1_q;

  // Stage two: add the second coefficient.
  logic signed [A1W-1:0] va1_d, va1_q, sa1_d, sa1_q;
  logic signed [CW-1:0]  cc2_q, cd2_q;
  logic [W-1:0]          w2_q;
  logic                  lin2_q;

  // Stage three: second multiplication by the weight.
  logic signed [M2W-1:0] vm2_d, vm2_q, sm2_d, sm2_q;
  logic signed [CW-1:0]  cc3_q, cd3_q;
  logic [W-1:0]          w3_q;
  logic                  lin3_q;

  // Stage four: add the third coefficient.
  logic signed [A2W-1:0] va2_d, va2_q, sa2_d, sa2_q;
  logic signed [CW-1:0]  cd4_q;
  logic [W-1:0]          w4_q;
  logic                  lin4_q;

  // Stage five: split partial products of the last value multiplication.
  logic [LPW-1:0]        lo_d, lo_q;
  logic signed [HPW-1:0] hi_d, hi_q;
  logic signed [A2W-1:0] sa5_q;
  logic signed [CW-1:0]  cd5_q;
  logic                  lin5_q;

  // Stage six: combine the partial products and add the constant term.
  logic signed [A3W-1:0] va3_d, va3_q;
  logic signed [A2W-1:0] sa6_q;
  logic                  lin6_q;

  logic signed [W1-1:0] ws0, ws2, ws4;

  assign ws0 = $signed({1'b0, weight_i});
  assign ws2 = $signed({1'b0, w2_q});
  assign ws4 = $signed({1'b0, w4_q});

  assign vm1_d = M1W'(ca_i) * M1W'(ws0);
  assign sm1_d = M1W'(sca_i) * M1W'(ws0);

  assign va1_d = A1W'(vm1_q) + (A1W'(cb1_q) <<< F);
  assign sa1_d = A1W'(sm1_q) + (A1W'(cb1_q) <<< (F + 1));

  assign vm2_d = M2W'(va1_q) * M2W'(ws2);
  assign sm2_d = M2W'(sa1_q) * M2W'(ws2);

  assign va2_d = A2W'(vm2_q) + (A2W'(cc3_q) <<< (2 * F));
  assign sa2_d = A2W'(sm2_q) + (A2W'(cc3_q) <<< (2 * F));

  assign lo_d = LPW'(va2_q[LO_W-1:0]) * LPW'(w4_q);
  assign hi_d = HPW'($signed(va2_q[A2W-1:LO_W])) * HPW'(ws4);

  assign va3_d = (A3W'(hi_q) <<< LO_W) + A3W'($signed({1'b0, lo_q}))
               + (A3W'(cd5_q) <<< (3 * F));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      vm1_q  <= vm1_d;
      sm1_q  <= sm1_d;
      cb1_q  <= cb_i;
      cc1_q  <= cc_i;
      cd1_q  <= cd_i;
      w1_q   <= weight_i;
      lin1_q <= lin_i;
    end
    if (en_i[1]) begin
      va1_q  <= va1_d;
      sa1_q  <= sa1_d;
      cc2_q  <= cc1_q;
      cd2_q  <= cd1_q;
      w2_q   <= w1_q;
      lin2_q <= lin1_q;
    end
    if (en_i[2]) begin
      vm2_q  <= vm2_d;
      sm2_q  <= sm2_d;
      cc3_q  <= cc2_q;
      cd3_q  <= cd2_q;
      w3_q   <= w2_q;
      lin3_q <= lin2_q;
    end
    if (en_i[3]) begin
      va2_q  <= va2_d;
      sa2_q  <= sa2_d;
      cd4_q  <= cd3_q;
      w4_q   <= w3_q;
      lin4_q <= lin3_q;
    end
    if (en_i[4]) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      sa5_q  <= sa2_q;
      cd5_q  <= cd4_q;
      lin5_q <= lin4_q;
    end
    if (en_i[5]) begin
      va3_q  <= va3_d;
      sa6_q  <= sa5_q;
      lin6_q <= lin5_q;
    end
  end

  assign value_num_o = va3_q;
  assign slope_num_o = sa6_q;
  assign lin_o       = lin6_q;

endmodule

### rtl/csi_round.sv
// ============================================================================
// Cubic spline interpolator rounding unit
// Rounds a wide numerator to nearest, ties upward, and saturates to 51 bits.
// ============================================================================
module csi_round #(
  parameter int IN_W  = 91,
  parameter int SHIFT = 33
) (
  input  logic signed [IN_W-1:0] num_i,
  output csi_pkg::out_word_t     result_o
);

  localparam int XW = ((IN_W + 1) > (csi_pkg::OUT_W + 1 + SHIFT)) ?
                      (IN_W + 1) : (csi_pkg::OUT_W + 1 + SHIFT);
  localparam logic signed [XW-1:0] HALF  = XW'(1) <<< (SHIFT - 1);
  localparam logic signed [XW-1:0] X_MAX = XW'(csi_pkg::OUT_MAX);
  localparam logic signed [XW-1:0] X_MIN = XW'(csi_pkg::OUT_MIN);

  logic signed [XW-1:0] biased;
  logic signed [XW-1:0] scaled;

  assign biased = XW'(num_i) + HALF;
  assign scaled = biased >>> SHIFT;

  always_comb begin
    priority if (scaled > X_MAX) begin
      result_o = csi_pkg::OUT_MAX;
    end else if (scaled < X_MIN) begin
      result_o = csi_pkg::OUT_MIN;
    end else begin
      result_o = scaled[csi_pkg::OUT_W-1:0];
    end
  end

endmodule

### rtl/cubic_spline_interpolator.sv
// ============================================================================
// Cubic spline interpolator
// Catmull-Rom interpolation of four control points with exact fixed point.
// ============================================================================
//
//  Channel  Direction  Payload
//  in_i     sink       weight, point_before/start/end/after, wrap_angles,
//                      linear_mode
//  out_o    source     value, slope
//
//  One transaction is accepted per cycle unless every stage is full and the output
//  stalls; each result passes through the nine-stage pipeline: unwrap,
//  coefficients, six Horner stages and the rounding output register.
//  Reset clears the stage valid bits only.
//  A stall holds only the stages that are full from the output back, so bubbles
//  close up and input is taken while a result waits.
//
module cubic_spline_interpolator #(
  parameter int WEIGHT_FRAC_BITS = 16,
  parameter int POINT_WIDTH      = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  csi_in_if.sink       in_i,
  csi_out_if.source    out_o
);

  `include "cubic_spline_interpolator_macros.svh"

  localparam int F   = WEIGHT_FRAC_BITS;
  localparam int PW  = POINT_WIDTH;
  localparam int NS  = 9;
  localparam int UW  = PW + 3;
  localparam int CW  = PW + 9;
  localparam int A2W = PW + 2 * F + 15;
  localparam int A3W = PW + 3 * F + 18;
  localparam int KV  = 3 * F + 1 - csi_pkg::OUT_FRAC;
  localparam int KS  = 2 * F + 1 - csi_pkg::OUT_FRAC;

  logic [NS-1:0] en;
  logic [NS-1:0] v_d, v_q;

  logic [F:0]           w_u, w_c;
  logic signed [UW-1:0] p_u, c_u, n_u, f_u;
  logic                 lin_u, lin_c, lin_p;
  logic signed [CW-1:0] ca_c, sca_c, cb_c, cc_c, cd_c;
  logic signed [A3W-1:0] value_num;
  logic signed [A2W-1:0] slope_num;

  csi_pkg::out_word_t value_rnd, slope_rnd;
  csi_pkg::out_word_t value_d, value_q, slope_d, slope_q;
  logic               out_lin_d, out_lin_q;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_o.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_comb begin
    v_d[0] = en[0] ? in_i.valid : v_q[0];
    for (int i = 1; i < NS; i++) begin
      v_d[i] = en[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  csi_unwrap #(.PW(PW), .F(F)) u_unwrap (
    .clk_i          (clk_i),
    .en_i           (en[0]),
    .weight_i       (in_i.weight),
    .point_before_i (in_i.point_before),
    .point_start_i  (in_i.point_start),
    .point_end_i    (in_i.point_end),
    .point_after_i  (in_i.point_after),
    .wrap_angles_i  (in_i.wrap_angles),
    .linear_mode_i  (in_i.linear_mode),
    .weight_o       (w_u),
    .p_o            (p_u),
    .c_o            (c_u),
    .n_o            (n_u),
    .f_o            (f_u),
    .lin_o          (lin_u)
  );

  csi_coeff #(.PW(PW), .F(F)) u_coeff (
    .clk_i    (clk_i),
    .en_i     (en[1]),
    .weight_i (w_u),
    .p_i      (p_u),
    .c_i      (c_u),
    .n_i      (n_u),
    .f_i      (f_u),
    .lin_i    (lin_u),
    .weight_o (w_c),
    .ca_o     (ca_c),
    .sca_o    (sca_c),
    .cb_o     (cb_c),
    .cc_o     (cc_c),
    .cd_o     (cd_c),
    .lin_o    (lin_c)
  );

  csi_poly #(.PW(PW), .F(F)) u_poly (
    .clk_i       (clk_i),
    .en_i        (en[7:2]),
    .weight_i    (w_c),
    .ca_i        (ca_c),
    .sca_i       (sca_c),
    .cb_i        (cb_c),
    .cc_i        (cc_c),
    .cd_i        (cd_c),
    .lin_i       (lin_c),
    .value_num_o (value_num),
    .slope_num_o (slope_num),
    .lin_o       (lin_p)
  );

  csi_round #(.IN_W(A3W), .SHIFT(KV)) u_round_value (
    .num_i    (value_num),
    .result_o (value_rnd)
  );

  csi_round #(.IN_W(A2W), .SHIFT(KS)) u_round_slope (
    .num_i    (slope_num),
    .result_o (slope_rnd)
  );

  assign value_d   = value_rnd;
  assign slope_d   = lin_p ? '0 : slope_rnd;
  assign out_lin_d = lin_p;

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      value_q   <= value_d;
      slope_q   <= slope_d;
      out_lin_q <= out_lin_d;
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = v_q[NS-1];
  assign out_o.value = value_q;
  assign out_o.slope = slope_q;

  `CSI_ASSERT_IMPL(a_lin_slope_zero, clk_i, rst_ni, out_o.valid && out_lin_q, out_o.slope == '0)
  `CSI_ASSERT_IMPL(a_ready_on_bubble, clk_i, rst_ni, v_q != '1, in_i.ready)
  `CSI_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_i.valid && in_i.ready, v_q[0])
  `CSI_ASSERT_NEXT(a_result_held, clk_i, rst_ni, v_q[NS-1] && !out_o.ready, v_q[NS-1])

endmodule

### tb/tb_cubic_spline_interpolator.sv
// ============================================================================
// Cubic spline interpolator testbench
// Drives directed and random control point sets through the valid/ready
// input channel, predicts each Catmull-Rom or linear result in exact wide
// arithmetic, and compares every result with the oldest prediction while
// the channel sides idle and stall at random in some phases.
// ============================================================================
`timescale 1ns / 1ps

module tb_cubic_spline_interpolator;

  localparam int WFB          = 16;
  localparam int PW           = 32;
  localparam int ONE          = 1 << WFB;
  localparam int STALL_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 200;
  localparam logic signed [PW-1:0] PMAX = 32'sh7fffffff;
  localparam logic signed [PW-1:0] PMIN = 32'sh80000000;

  typedef struct {
    logic [WFB:0]         weight;
    logic signed [PW-1:0] pt_before;
    logic signed [PW-1:0] pt_start;
    logic signed [PW-1:0] pt_end;
    logic signed [PW-1:0] pt_after;
    logic                 wrap_angles;
    logic                 linear_mode;
  } spline_req_t;

  typedef struct {
    csi_pkg::out_word_t value;
    csi_pkg::out_word_t slope;
  } spline_res_t;

  class spline_scoreboard;
    spline_res_t pending_samples[$];
    int errors;
    int checked;
    int n_cubic;
    int n_linear;
    int n_wrap;

    function logic signed [127:0] turn_offset(logic signed [127:0] a,
                                              logic signed [127:0] b);
      logic signed [127:0] d;
      d = b - a;
      if (d >= csi_pkg::STEP_HI_LIMIT) return -(128'sd1 <<< csi_pkg::TURN_BITS);
      if (d < csi_pkg::STEP_LO_LIMIT) return 128'sd1 <<< csi_pkg::TURN_BITS;
      return 128'sd0;
    endfunction

    function csi_pkg::out_word_t round_q16(logic signed [127:0] num, int shift);
      logic signed [127:0] r;
      r = (num + (128'sd1 <<< (shift - 1))) >>> shift;
      if (r > csi_pkg::OUT_MAX) return csi_pkg::OUT_MAX;
      if (r < csi_pkg::OUT_MIN) return csi_pkg::OUT_MIN;
      return r[csi_pkg::OUT_W-1:0];
    endfunction

    function spline_res_t interpolate(spline_req_t rq);
      logic signed [127:0] p, c, n, f, off;
      logic signed [127:0] ca, cb, cc, cd, t, u, vnum, snum;
      spline_res_t res;
      u = 128'sd1 <<< WFB;
      t = '0;
      t[WFB:0] = rq.weight;
      if (t > u) t = u;
      p = 128'(rq.pt_before);
      c = 128'(rq.pt_start);
      n = 128'(rq.pt_end);
      f = 128'(rq.pt_after);
      if (rq.wrap_angles) begin
        off = turn_offset(p, c);
        c += off;
        n += off;
        f += off;
        off = turn_offset(c, n);
        n += off;
        f += off;
        f += turn_offset(n, f);
      end
      if (rq.linear_mode) begin
        ca = '0;
        cb = '0;
        cc = 2 * (n - c);
      end else begin
        ca = -p + 3 * c - 3 * n + f;
        cb = 2 * p - 5 * c + 4 * n - f;
        cc = n - p;
      end
      cd = 2 * c;
      vnum = ((ca * t + cb * u) * t + cc * u * u) * t + cd * u * u * u;
      res.value = round_q16(vnum, 3 * WFB + 1 - csi_pkg::OUT_FRAC);
      if (rq.linear_mode) begin
        res.slope = '0;
      end else begin
        snum = (3 * ca * t + 2 * cb * u) * t + cc * u * u;
        res.slope = round_q16(snum, 2 * WFB + 1 - csi_pkg::OUT_FRAC);
      end
      return res;
    endfunction

    function void note_transaction(spline_req_t rq);
      pending_samples.push_back(interpolate(rq));
      if (rq.linear_mode) n_linear++;
      else n_cubic++;
      if (rq.wrap_angles) n_wrap++;
    endfunction

    function void check_result(csi_pkg::out_word_t value, csi_pkg::out_word_t slope);
      spline_res_t want;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected result value %0d slope %0d", $time, value, slope);
        errors++;
        return;
      end
      want = pending_samples.pop_front();
      checked++;
      if (value !== want.value) begin
        $display("%0t: value mismatch, expected %0d, got %0d", $time, want.value, value);
        errors++;
      end
      if (slope !== want.slope) begin
        $display("%0t: slope mismatch, expected %0d, got %0d", $time, want.slope, slope);
        errors++;
      end
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   stuck_cycles;
  spline_scoreboard sb;

  csi_in_if #(.POINT_WIDTH(PW), .WEIGHT_FRAC_BITS(WFB)) in_ch ();
  csi_out_if out_ch ();

  cubic_spline_interpolator #(
    .WEIGHT_FRAC_BITS(WFB),
    .POINT_WIDTH     (PW)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_transaction(spline_req_t'{in_ch.weight, in_ch.point_before, in_ch.point_start,
                                          in_ch.point_end, in_ch.point_after,
                                          in_ch.wrap_angles, in_ch.linear_mode});
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.value, out_ch.slope);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic spline_req_t make_req(int w, logic signed [PW-1:0] pb,
                                           logic signed [PW-1:0] ps, logic signed [PW-1:0] pe,
                                           logic signed [PW-1:0] pa, bit wrap, bit lin);
    spline_req_t rq;
    rq.weight      = w[WFB:0];
    rq.pt_before   = pb;
    rq.pt_start    = ps;
    rq.pt_end      = pe;
    rq.pt_after    = pa;
    rq.wrap_angles = wrap;
    rq.linear_mode = lin;
    return rq;
  endfunction

  function automatic logic signed [PW-1:0] rand_point();
    case ($urandom_range(3))
      0: return $urandom;
      1: return PW'($urandom_range(2000)) - 1000;
      2: begin
        case ($urandom_range(3))
          0: return PMAX;
          1: return PMIN;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return PW'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic signed [PW-1:0] rand_step();
    case ($urandom_range(5))
      0: return 32'sh8000;
      1: return 32'sh8001;
      2: return -32'sh8000;
      3: return -32'sh8001;
      4: return $urandom;
      default: return PW'($urandom_range(32'h1ffff)) - 32'h10000;
    endcase
  endfunction

  function automatic spline_req_t rand_item();
    spline_req_t rq;
    rq.wrap_angles = 1'($urandom_range(1));
    rq.linear_mode = ($urandom_range(3) == 0);
    case ($urandom_range(9))
      0: rq.weight = '0;
      1: rq.weight = (WFB+1)'(ONE);
      2: rq.weight = (WFB+1)'($urandom_range(2 * ONE - 1, ONE + 1));
      default: rq.weight = (WFB+1)'($urandom_range(ONE - 1));
    endcase
    if ($urandom_range(1)) begin
      rq.pt_before = rand_point();
      rq.pt_start  = rq.pt_before + rand_step();
      rq.pt_end    = rq.pt_start + rand_step();
      rq.pt_after  = rq.pt_end + rand_step();
    end else begin
      rq.pt_before = rand_point();
      rq.pt_start  = rand_point();
      rq.pt_end    = rand_point();
      rq.pt_after  = rand_point();
    end
    return rq;
  endfunction

  task automatic send_item(input spline_req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.weight       <= rq.weight;
    in_ch.point_before <= rq.pt_before;
    in_ch.point_start  <= rq.pt_start;
    in_ch.point_end    <= rq.pt_end;
    in_ch.point_after  <= rq.pt_after;
    in_ch.wrap_angles  <= rq.wrap_angles;
    in_ch.linear_mode  <= rq.linear_mode;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    sb = new();
    rst_n              = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    in_ch.valid        = 1'b0;
    in_ch.weight       = '0;
    in_ch.point_before = '0;
    in_ch.point_start  = '0;
    in_ch.point_end    = '0;
    in_ch.point_after  = '0;
    in_ch.wrap_angles  = 1'b0;
    in_ch.linear_mode  = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item(make_req(0, 0, 0, 0, 0, 0, 0));
    send_item(make_req(ONE, PMAX, PMAX, PMAX, PMAX, 0, 0));
    send_item(make_req(ONE / 2, PMIN, PMIN, PMIN, PMIN, 0, 0));
    send_item(make_req(ONE / 2, PMIN, PMAX, PMIN, PMAX, 0, 0));
    send_item(make_req(ONE, PMAX, PMIN, PMAX, PMIN, 0, 0));
    send_item(make_req(1, PMIN, PMAX, PMAX, PMIN, 0, 0));
    send_item(make_req(ONE - 1, PMAX, PMIN, PMIN, PMAX, 0, 0));
    send_item(make_req(2 * ONE - 1, 10, 20, 30, 40, 0, 0));
    send_item(make_req(ONE + 1, -5, 100, -100, 5, 0, 1));
    send_item(make_req(0, PMAX, PMIN, PMAX, PMIN, 0, 1));
    send_item(make_req(ONE, 0, PMIN, PMAX, 0, 0, 1));
    send_item(make_req(ONE / 3, 1, -1, 1, -1, 0, 1));
    send_item(make_req(ONE / 2, 0, 32'sh8000, 32'sh10000, 32'sh18000, 1, 0));
    send_item(make_req(ONE / 2, 0, 32'sh8001, 32'sh10002, 32'sh18003, 1, 0));
    send_item(make_req(ONE / 2, 0, -32'sh8000, -32'sh10000, -32'sh18000, 1, 0));
    send_item(make_req(ONE / 2, 0, -32'sh8001, -32'sh10002, -32'sh18003, 1, 0));
    send_item(make_req(ONE / 4, PMIN, PMAX, PMIN, PMAX, 1, 0));
    send_item(make_req(ONE / 4, PMAX, PMIN, PMAX, PMIN, 1, 1));
    send_item(make_req(3 * ONE / 4, 100, 65000, 200, 65500, 1, 1));
    send_item(make_req(2 * ONE - 1, 65535, 0, 65535, 0, 1, 0));

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 64 : (ph == 3) ? 27 : 0;
      recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 27 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) pause_until_drained();
        send_item(rand_item());
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d results: %0d cubic and %0d linear transactions, %0d unwrapped.",
             sb.checked, sb.n_cubic, sb.n_linear, sb.n_wrap);
    $display("Random traffic ran with no idling, sender gaps, receiver stalls and both at once.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    wait (rst_n);
    while (stuck_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/csi_pkg.sv
rtl/csi_if.sv
rtl/csi_unwrap.sv
rtl/csi_coeff.sv
rtl/csi_poly.sv
rtl/csi_round.sv
rtl/cubic_spline_interpolator.sv
tb/tb_cubic_spline_interpolator.sv
